// ===== hw/rtl/fatc_pkg.sv =====
package fatc_pkg;

  localparam int unsigned MAX_BLOCKS = 1024;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned ENT_W = 11;

  localparam logic [ENT_W-1:0] END_MARK = 11'd1024;
  localparam logic [ENT_W-1:0] MIN_USED = 11'd2;

  localparam logic [2:0] CMD_ALLOC  = 3'd0;
  localparam logic [2:0] CMD_FREE   = 3'd1;
  localparam logic [2:0] CMD_EXTEND = 3'd2;
  localparam logic [2:0] CMD_TRUNC  = 3'd3;
  localparam logic [2:0] CMD_QUERY  = 3'd4;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOSPACE = 2'd1;
  localparam logic [1:0] STAT_INVALID = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_READ,
    S_FREE,
    S_EXT,
    S_GRAB_RD,
    S_GRAB,
    S_TRUNC,
    S_TAIL,
    S_TAIL_FREE,
    S_RC_RD,
    S_RC
  } state_t;

endpackage

// ===== hw/rtl/fat_chain_block_allocator_core.sv =====
// Chained-block allocation table of 1024 entries with one result per command. A command is
// taken when start is high and busy is low; its result shows for one cycle with done high and
// cannot be held off. All work goes through one table RAM port pair: allocate scans entries 1
// to n-1, extend walks the chain to its end mark and then scans, free and truncate walk the
// chain, and query touches no table entry. After reset the table is cleared with busy high;
// a table_blocks write (cfg_valid, cfg_ready) recounts free entries with busy high and gives
// no result.
module fat_chain_block_allocator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [9:0]  start_block,
  input  logic [10:0] chain_length,
  input  logic [10:0] block_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [9:0]  first_block,
  output logic [9:0]  last_block,
  output logic [10:0] free_blocks
);

  localparam int unsigned DEPTH = fatc_pkg::MAX_BLOCKS;
  localparam int unsigned IW = fatc_pkg::IDX_W;
  localparam int unsigned EW = fatc_pkg::ENT_W;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] mem_q;

  fatc_pkg::state_t state, state_next, ret, ret_next;

  logic [2:0]    cmd_r, cmd_next;
  logic [IW-1:0] start_r, start_next;
  logic [EW-1:0] len_r, len_next;
  logic [EW-1:0] cnt_r, cnt_next;
  logic [EW-1:0] ptr, ptr_next;
  logic [IW-1:0] tail, tail_next;
  logic [EW-1:0] rem, rem_next;
  logic [EW-1:0] steps, steps_next;
  logic [IW-1:0] first, first_next;
  logic [EW-1:0] free_total, free_next;
  logic [EW-1:0] tb, tb_next;
  logic          pend, pend_next;
  logic [IW-1:0] pend_addr, pend_addr_next;
  logic [IW-1:0] pend_data, pend_data_next;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata;
  logic          fin;
  logic [1:0]    fin_status;
  logic [IW-1:0] fin_last;

  logic [EW-1:0] n;
  logic          q_link, ptr_link, start_ok, len_bad;

  always_comb begin
    if (tb < fatc_pkg::MIN_USED) begin
      n = fatc_pkg::MIN_USED;
    end else if (tb > fatc_pkg::END_MARK) begin
      n = fatc_pkg::END_MARK;
    end else begin
      n = tb;
    end
  end

  assign q_link   = (mem_q != '0) && (mem_q < n);
  assign ptr_link = (ptr != '0) && (ptr < n);
  assign start_ok = (start_r != '0) && ({1'b0, start_r} < n) && (mem_q != '0);
  assign len_bad  = (cnt_r > len_r) || (cnt_r == len_r);

  assign busy      = (state != fatc_pkg::S_IDLE);
  assign cfg_ready = (state == fatc_pkg::S_IDLE) && !start;

  always_comb begin
    state_next = state;
    unique case (state)
      fatc_pkg::S_CLEAR: begin
        if (ptr[IW-1:0] == '1) state_next = fatc_pkg::S_IDLE;
      end
      fatc_pkg::S_IDLE: begin
        if (start) begin
          unique case (command)
            fatc_pkg::CMD_ALLOC: begin
              if (block_count != '0 && block_count <= free_total) begin
                state_next = fatc_pkg::S_GRAB_RD;
              end
            end
            fatc_pkg::CMD_FREE, fatc_pkg::CMD_EXTEND, fatc_pkg::CMD_TRUNC: begin
              state_next = fatc_pkg::S_CHECK;
            end
            default: state_next = fatc_pkg::S_IDLE;
          endcase
        end else if (cfg_valid) begin
          state_next = fatc_pkg::S_RC_RD;
        end
      end
      fatc_pkg::S_CHECK: begin
        if (!start_ok) begin
          state_next = fatc_pkg::S_IDLE;
        end else begin
          unique case (cmd_r)
            fatc_pkg::CMD_FREE: begin
              state_next = (len_r == '0) ? fatc_pkg::S_IDLE : fatc_pkg::S_FREE;
            end
            fatc_pkg::CMD_EXTEND: state_next = fatc_pkg::S_EXT;
            default: state_next = len_bad ? fatc_pkg::S_IDLE : fatc_pkg::S_TRUNC;
          endcase
        end
      end
      fatc_pkg::S_READ: state_next = ret;
      fatc_pkg::S_FREE: begin
        if (!ptr_link || mem_q == '0 || mem_q == fatc_pkg::END_MARK || rem == 11'd1) begin
          state_next = fatc_pkg::S_IDLE;
        end else begin
          state_next = fatc_pkg::S_READ;
        end
      end
      fatc_pkg::S_EXT: begin
        if (mem_q == fatc_pkg::END_MARK) begin
          state_next = (cnt_r > free_total) ? fatc_pkg::S_IDLE : fatc_pkg::S_GRAB_RD;
        end else if (!q_link || steps >= n) begin
          state_next = fatc_pkg::S_IDLE;
        end else begin
          state_next = fatc_pkg::S_READ;
        end
      end
      fatc_pkg::S_GRAB_RD: begin
        state_next = (rem == '0 || ptr >= n) ? fatc_pkg::S_IDLE : fatc_pkg::S_GRAB;
      end
      fatc_pkg::S_GRAB: state_next = fatc_pkg::S_GRAB_RD;
      fatc_pkg::S_TRUNC: begin
        if (rem == '0) begin
          state_next = fatc_pkg::S_TAIL;
        end else if (!q_link) begin
          state_next = fatc_pkg::S_IDLE;
        end else begin
          state_next = fatc_pkg::S_READ;
        end
      end
      fatc_pkg::S_TAIL: begin
        if (ptr == fatc_pkg::END_MARK || !ptr_link || ptr == {1'b0, tail}) begin
          state_next = fatc_pkg::S_IDLE;
        end else begin
          state_next = fatc_pkg::S_READ;
        end
      end
      fatc_pkg::S_TAIL_FREE: begin
        state_next = (mem_q == '0) ? fatc_pkg::S_IDLE : fatc_pkg::S_TAIL;
      end
      fatc_pkg::S_RC_RD: state_next = (ptr >= n) ? fatc_pkg::S_IDLE : fatc_pkg::S_RC;
      fatc_pkg::S_RC: state_next = fatc_pkg::S_RC_RD;
      default: state_next = fatc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_next       = cmd_r;
    start_next     = start_r;
    len_next       = len_r;
    cnt_next       = cnt_r;
    ptr_next       = ptr;
    tail_next      = tail;
    rem_next       = rem;
    steps_next     = steps;
    first_next     = first;
    free_next      = free_total;
    tb_next        = tb;
    pend_next      = pend;
    pend_addr_next = pend_addr;
    pend_data_next = pend_data;
    ret_next       = ret;
    we             = 1'b0;
    waddr          = ptr[IW-1:0];
    wdata          = '0;
    raddr          = ptr[IW-1:0];
    fin            = 1'b0;
    fin_status     = fatc_pkg::STAT_OK;
    fin_last       = '0;
    unique case (state)
      fatc_pkg::S_CLEAR: begin
        we       = 1'b1;
        wdata    = (ptr[IW-1:0] == '0) ? fatc_pkg::END_MARK : '0;
        ptr_next = ptr + 11'd1;
      end
      fatc_pkg::S_IDLE: begin
        raddr = start_block;
        if (start) begin
          cmd_next   = command;
          start_next = start_block;
          len_next   = chain_length;
          cnt_next   = block_count;
          first_next = '0;
          unique case (command)
            fatc_pkg::CMD_ALLOC: begin
              if (block_count == '0) begin
                fin        = 1'b1;
                fin_status = fatc_pkg::STAT_INVALID;
              end else if (block_count > free_total) begin
                fin        = 1'b1;
                fin_status = fatc_pkg::STAT_NOSPACE;
              end else begin
                ptr_next  = 11'd1;
                tail_next = '0;
                rem_next  = block_count;
                pend_next = 1'b0;
              end
            end
            fatc_pkg::CMD_FREE, fatc_pkg::CMD_EXTEND, fatc_pkg::CMD_TRUNC: begin
            end
            fatc_pkg::CMD_QUERY: fin = 1'b1;
            default: begin
              fin        = 1'b1;
              fin_status = fatc_pkg::STAT_INVALID;
            end
          endcase
        end else if (cfg_valid) begin
          tb_next   = cfg_data;
          ptr_next  = 11'd1;
          free_next = '0;
        end
      end
      fatc_pkg::S_CHECK: begin
        raddr      = start_r;
        first_next = start_r;
        if (!start_ok) begin
          fin        = 1'b1;
          fin_status = fatc_pkg::STAT_INVALID;
        end else begin
          ptr_next = {1'b0, start_r};
          unique case (cmd_r)
            fatc_pkg::CMD_FREE: begin
              rem_next = len_r;
              ret_next = fatc_pkg::S_FREE;
              if (len_r == '0) begin
                fin        = 1'b1;
                fin_status = fatc_pkg::STAT_INVALID;
              end
            end
            fatc_pkg::CMD_EXTEND: begin
              steps_next = '0;
              ret_next   = fatc_pkg::S_EXT;
            end
            default: begin
              rem_next = len_r - cnt_r - 11'd1;
              ret_next = fatc_pkg::S_TRUNC;
              if (len_bad) begin
                fin        = 1'b1;
                fin_status = fatc_pkg::STAT_INVALID;
              end
            end
          endcase
        end
      end
      fatc_pkg::S_READ: begin
      end
      fatc_pkg::S_FREE: begin
        if (!ptr_link || mem_q == '0) begin
          fin        = 1'b1;
          fin_status = fatc_pkg::STAT_INVALID;
        end else begin
          we        = 1'b1;
          free_next = free_total + 11'd1;
          if (mem_q == fatc_pkg::END_MARK) begin
            fin        = 1'b1;
            fin_status = (rem > 11'd1) ? fatc_pkg::STAT_INVALID : fatc_pkg::STAT_OK;
          end else begin
            ptr_next = mem_q;
            rem_next = rem - 11'd1;
            fin      = (rem == 11'd1);
          end
        end
      end
      fatc_pkg::S_EXT: begin
        if (mem_q == fatc_pkg::END_MARK) begin
          if (cnt_r > free_total) begin
            fin        = 1'b1;
            fin_status = fatc_pkg::STAT_NOSPACE;
          end else begin
            tail_next = ptr[IW-1:0];
            ptr_next  = 11'd1;
            rem_next  = cnt_r;
            pend_next = 1'b0;
          end
        end else if (!q_link || steps >= n) begin
          fin        = 1'b1;
          fin_status = fatc_pkg::STAT_INVALID;
        end else begin
          ptr_next   = mem_q;
          steps_next = steps + 11'd1;
        end
      end
      fatc_pkg::S_GRAB_RD: begin
        if (pend) begin
          we        = 1'b1;
          waddr     = pend_addr;
          wdata     = {1'b0, pend_data};
          pend_next = 1'b0;
        end
        if (rem == '0 || ptr >= n) begin
          fin      = 1'b1;
          fin_last = tail;
        end
      end
      fatc_pkg::S_GRAB: begin
        ptr_next = ptr + 11'd1;
        if (mem_q == '0) begin
          we    = 1'b1;
          wdata = fatc_pkg::END_MARK;
          if (tail != '0) begin
            pend_next      = 1'b1;
            pend_addr_next = tail;
            pend_data_next = ptr[IW-1:0];
          end else begin
            first_next = ptr[IW-1:0];
          end
          tail_next = ptr[IW-1:0];
          rem_next  = rem - 11'd1;
          free_next = free_total - 11'd1;
        end
      end
      fatc_pkg::S_TRUNC: begin
        if (rem == '0) begin
          we        = 1'b1;
          wdata     = fatc_pkg::END_MARK;
          tail_next = ptr[IW-1:0];
          ptr_next  = mem_q;
        end else if (!q_link) begin
          fin        = 1'b1;
          fin_status = fatc_pkg::STAT_INVALID;
        end else begin
          ptr_next = mem_q;
          rem_next = rem - 11'd1;
        end
      end
      fatc_pkg::S_TAIL: begin
        ret_next = fatc_pkg::S_TAIL_FREE;
        if (ptr == fatc_pkg::END_MARK) begin
          fin      = 1'b1;
          fin_last = tail;
        end else if (!ptr_link || ptr == {1'b0, tail}) begin
          fin        = 1'b1;
          fin_status = fatc_pkg::STAT_INVALID;
        end
      end
      fatc_pkg::S_TAIL_FREE: begin
        if (mem_q == '0) begin
          fin        = 1'b1;
          fin_status = fatc_pkg::STAT_INVALID;
        end else begin
          we        = 1'b1;
          free_next = free_total + 11'd1;
          ptr_next  = mem_q;
        end
      end
      fatc_pkg::S_RC_RD: begin
      end
      fatc_pkg::S_RC: begin
        ptr_next = ptr + 11'd1;
        if (mem_q == '0) free_next = free_total + 11'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fatc_pkg::S_CLEAR;
      ret        <= fatc_pkg::S_IDLE;
      ptr        <= '0;
      tb         <= fatc_pkg::END_MARK;
      free_total <= fatc_pkg::END_MARK - 11'd1;
      pend       <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      ret        <= ret_next;
      ptr        <= ptr_next;
      tb         <= tb_next;
      free_total <= free_next;
      pend       <= pend_next;
      done       <= fin;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_next;
    start_r   <= start_next;
    len_r     <= len_next;
    cnt_r     <= cnt_next;
    tail      <= tail_next;
    rem       <= rem_next;
    steps     <= steps_next;
    first     <= first_next;
    pend_addr <= pend_addr_next;
    pend_data <= pend_data_next;
    if (fin) begin
      status      <= fin_status;
      first_block <= first_next;
      last_block  <= fin_last;
      free_blocks <= free_next;
    end
  end

endmodule
